@@ rtl/smr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream first-match replace package
// Shared payload types, register indexes and sizing constants.
// ----------------------------------------------------------------------------
package smr_pkg;

  localparam int CHAR_W      = 8;
  localparam int JOB_CHARS   = 8;
  localparam int COUNT_W     = 4;
  localparam int JOB_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  typedef struct packed {
    logic [CHAR_W-1:0] in_char;
    logic              in_line_end;
  } smr_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              char_present;
    logic              out_line_end;
  } smr_out_t;

  typedef struct packed {
    logic [JOB_CHARS-1:0][CHAR_W-1:0] chars;
    logic [COUNT_W-1:0]               count;
    logic                             present;
    logic                             line_end;
  } smr_job_t;

endpackage

@@ rtl/smr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream first-match replace front end
// Holds the configuration and the character window, compares the window
// against the pattern and turns each request into at most one emission job.
// ----------------------------------------------------------------------------
module smr_front #(
  parameter int MAX_PATTERN_CHARS     = 8,
  parameter int MAX_REPLACEMENT_CHARS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [smr_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [smr_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  accept,
  input  smr_pkg::smr_in_t                      item,
  output logic                                  job_push,
  output smr_pkg::smr_job_t                     job
);

  localparam int WIN_N  = MAX_PATTERN_CHARS;
  localparam int REP_N  = MAX_REPLACEMENT_CHARS;
  localparam int FILL_W = $clog2(WIN_N + 1);
  localparam int PAT_W  = WIN_N * smr_pkg::CHAR_W;
  localparam int REP_W  = REP_N * smr_pkg::CHAR_W;

  logic [WIN_N-1:0][smr_pkg::CHAR_W-1:0] pattern_bytes;
  logic [smr_pkg::COUNT_W-1:0]           pattern_length;
  logic [REP_N-1:0][smr_pkg::CHAR_W-1:0] replacement_bytes;
  logic [smr_pkg::COUNT_W-1:0]           replacement_length;

  logic [WIN_N-1:0][smr_pkg::CHAR_W-1:0] window;
  logic [WIN_N-1:0][smr_pkg::CHAR_W-1:0] window_next;
  logic [FILL_W-1:0]                     fill;
  logic [FILL_W-1:0]                     fill_next;
  logic                                  replaced;
  logic                                  replaced_next;

  logic [smr_pkg::COUNT_W-1:0]           plen;
  logic [smr_pkg::COUNT_W-1:0]           rlen;
  logic [WIN_N-1:0][smr_pkg::CHAR_W-1:0] win_a;
  logic [FILL_W-1:0]                     fill_a;
  logic                                  equal;
  logic                                  hit;
  logic                                  pop;
  logic                                  push_raw;
  logic [smr_pkg::JOB_CHARS-1:0][smr_pkg::CHAR_W-1:0] win_chars;
  logic [smr_pkg::JOB_CHARS-1:0][smr_pkg::CHAR_W-1:0] rep_chars;

  always_comb begin
    if (pattern_length == '0) begin
      plen = smr_pkg::COUNT_W'(1);
    end else if (pattern_length > smr_pkg::COUNT_W'(WIN_N)) begin
      plen = smr_pkg::COUNT_W'(WIN_N);
    end else begin
      plen = pattern_length;
    end
    if (replacement_length > smr_pkg::COUNT_W'(REP_N)) begin
      rlen = smr_pkg::COUNT_W'(REP_N);
    end else begin
      rlen = replacement_length;
    end
  end

  always_comb begin
    win_a  = window;
    fill_a = fill;
    if (fill < FILL_W'(WIN_N)) begin
      for (int i = 0; i < WIN_N; i++) begin
        if (FILL_W'(i) == fill) begin
          win_a[i] = item.in_char;
        end
      end
      fill_a = fill + FILL_W'(1);
    end

    equal = 1'b1;
    for (int i = 0; i < WIN_N; i++) begin
      if (smr_pkg::COUNT_W'(i) < plen && win_a[i] != pattern_bytes[i]) begin
        equal = 1'b0;
      end
    end
    hit = !replaced && smr_pkg::COUNT_W'(fill_a) == plen && equal;
    pop = smr_pkg::COUNT_W'(fill_a) >= plen;

    for (int i = 0; i < smr_pkg::JOB_CHARS; i++) begin
      win_chars[i] = (i < WIN_N) ? win_a[i] : '0;
      rep_chars[i] = (i < REP_N) ? replacement_bytes[i] : '0;
    end
  end

  always_comb begin
    job          = '0;
    push_raw     = 1'b0;
    job.present  = 1'b1;
    job.line_end = item.in_line_end;
    if (hit) begin
      job.chars = rep_chars;
      job.count = rlen;
      if (item.in_line_end) begin
        push_raw = 1'b1;
        if (rlen == '0) begin
          job.chars   = '0;
          job.count   = smr_pkg::COUNT_W'(1);
          job.present = 1'b0;
        end
      end else begin
        push_raw = rlen != '0;
      end
    end else if (item.in_line_end) begin
      job.chars = win_chars;
      job.count = smr_pkg::COUNT_W'(fill_a);
      push_raw  = 1'b1;
    end else if (pop) begin
      job.chars = win_chars;
      job.count = smr_pkg::COUNT_W'(1);
      push_raw  = 1'b1;
    end
    job_push = accept && push_raw;
  end

  always_comb begin
    window_next   = win_a;
    fill_next     = fill_a;
    replaced_next = replaced;
    if (item.in_line_end || hit) begin
      fill_next     = '0;
      replaced_next = !item.in_line_end;
    end else if (pop) begin
      for (int i = 0; i < WIN_N; i++) begin
        window_next[i] = (i + 1 < WIN_N) ? win_a[(i + 1) % WIN_N] : '0;
      end
      fill_next = fill_a - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= smr_pkg::COUNT_W'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
      fill               <= '0;
      replaced           <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          smr_pkg::REG_PATTERN_BYTES:      pattern_bytes      <= cfg_data[PAT_W-1:0];
          smr_pkg::REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[smr_pkg::COUNT_W-1:0];
          smr_pkg::REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data[REP_W-1:0];
          smr_pkg::REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[smr_pkg::COUNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        fill     <= fill_next;
        replaced <= replaced_next;
      end
    end
    if (accept) begin
      window <= window_next;
    end
  end

endmodule

@@ rtl/smr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream first-match replace job queue
// A short first-in first-out buffer of emission jobs between front and back.
// ----------------------------------------------------------------------------
module smr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  smr_pkg::smr_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output smr_pkg::smr_job_t head
);

  smr_pkg::smr_job_t                 mem [smr_pkg::QUEUE_DEPTH];
  logic [smr_pkg::QPTR_W-1:0]        wptr;
  logic [smr_pkg::QPTR_W-1:0]        rptr;
  logic [smr_pkg::QCNT_W-1:0]        count;

  assign full       = count == smr_pkg::QCNT_W'(smr_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + smr_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + smr_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + smr_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - smr_pkg::QCNT_W'(1);
      end
    end
    if (push) begin
      mem[wptr] <= push_job;
    end
  end

endmodule

@@ rtl/smr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream first-match replace back end
// Expands each job into result requests, one character per cycle while the
// result side does not stall, into a registered output stage.
// ----------------------------------------------------------------------------
module smr_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  smr_pkg::smr_job_t head,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output smr_pkg::smr_out_t result_data
);

  logic                          busy;
  smr_pkg::smr_job_t             job;
  logic [smr_pkg::JOB_IDX_W-1:0] idx;

  smr_pkg::smr_job_t             cur;
  logic [smr_pkg::JOB_IDX_W-1:0] cur_idx;
  logic                          avail;
  logic                          slot_free;
  logic                          emit;
  logic                          last;

  always_comb begin
    cur       = busy ? job : head;
    cur_idx   = busy ? idx : '0;
    avail     = busy || head_valid;
    slot_free = !result_valid || !result_stall;
    emit      = slot_free && avail;
    last      = smr_pkg::COUNT_W'(cur_idx) + smr_pkg::COUNT_W'(1) == cur.count;
    pop       = emit && !busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (slot_free) begin
        result_valid <= avail;
      end
      if (emit) begin
        if (last) begin
          busy <= 1'b0;
        end else begin
          busy <= 1'b1;
        end
      end
    end
    if (emit) begin
      result_data.out_char     <= cur.chars[cur_idx];
      result_data.char_present <= cur.present;
      result_data.out_line_end <= cur.line_end && last;
      if (!last) begin
        idx <= cur_idx + smr_pkg::JOB_IDX_W'(1);
        if (!busy) begin
          job <= head;
        end
      end
    end
  end

endmodule

@@ rtl/stream_first_match_replace_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream first-match replace core
// Replaces the first occurrence of a pattern in each line of a character
// stream, with a window compare in front and a character emitter in back.
//
//   Channel   Signals                               Carries
//   cfg       cfg_write cfg_index cfg_data          register writes
//   char      char_valid char_stall char_data       one input character
//   result    result_valid result_stall result_data one output character
//
// A character request is taken every cycle while the job queue has room.
// Each job leaves one result per cycle unless the result side stalls, so
// a replacement of n characters gives n results from the back end.
// Reset is synchronous and clears the registers, window fill and queue.
// A stall on the result side fills the four-entry queue before char_stall rises.
// ----------------------------------------------------------------------------
module stream_first_match_replace_core #(
  parameter int MAX_PATTERN_CHARS     = 8,
  parameter int MAX_REPLACEMENT_CHARS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [smr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [smr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            char_valid,
  output logic                            char_stall,
  input  smr_pkg::smr_in_t                char_data,
  output logic                            result_valid,
  input  logic                            result_stall,
  output smr_pkg::smr_out_t               result_data
);

  logic              accept;
  logic              job_push;
  smr_pkg::smr_job_t job;
  logic              full;
  logic              pop;
  logic              head_valid;
  smr_pkg::smr_job_t head;

  assign char_stall = full;
  assign accept     = char_valid && !full;

  smr_front #(
    .MAX_PATTERN_CHARS    (MAX_PATTERN_CHARS),
    .MAX_REPLACEMENT_CHARS(MAX_REPLACEMENT_CHARS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .item     (char_data),
    .job_push (job_push),
    .job      (job)
  );

  smr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_job  (job),
    .full      (full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  smr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data (result_data)
  );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream first-match replace core testbench
// Drives lines of characters through the core under several pattern and
// replacement settings and checks every result against a fixed value or a
// predictor of the window, first-match replacement and end-of-line flush.
// A short directed sequence covers reset values, the extremes and the special
// lengths; random lines with embedded and broken patterns follow, with random
// gaps on both channels and one long result hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 190;
  localparam int SETTLE_CYCLES = 12;

  typedef enum logic {STEP_CHAR, STEP_WRITE} step_kind_t;
  typedef enum int {PACE_FULL, PACE_RANDOM, PACE_SPARSE} pace_t;

  typedef struct {
    step_kind_t                       kind;
    logic [smr_pkg::CFG_INDEX_W-1:0]  reg_index;
    logic [smr_pkg::CFG_DATA_W-1:0]   value;
    smr_pkg::smr_in_t                 req;
    bit                               has_fixed;
    smr_pkg::smr_out_t                fixed;
  } stim_row_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_write;
  logic [smr_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [smr_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                            char_valid;
  logic                            char_stall;
  smr_pkg::smr_in_t                char_data;
  logic                            result_valid;
  logic                            result_stall;
  smr_pkg::smr_out_t               result_data;

  // Predictor state and its copy of the registers.
  logic [63:0]  pat_bytes_q = '0;
  logic [3:0]   pat_len_q   = 4'd1;
  logic [63:0]  rep_bytes_q = '0;
  logic [3:0]   rep_len_q   = 4'd0;
  logic [7:0]   win [8]     = '{default: 8'h00};
  int unsigned  win_fill    = 0;
  bit           replaced    = 1'b0;

  smr_pkg::smr_out_t step_results [$];
  smr_pkg::smr_out_t pending_results [$];
  stim_row_t         directed_rows [$];

  pace_t        send_pace = PACE_RANDOM;
  pace_t        recv_pace = PACE_RANDOM;
  int           hold_off_cycles = 0;
  int           cycle_count = 0;
  int           fail_count = 0;
  int           results_checked = 0;
  int           matches_replaced = 0;
  int           input_stall_cycles = 0;
  int           directed_items = 0;
  int           random_items = 0;
  int           phase_count = 0;
  smr_pkg::smr_out_t want;

  stream_first_match_replace_core i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("stream_first_match_replace_core verification failed");
    $finish;
  end

  function automatic int pick_wait(input pace_t pace);
    if (pace == PACE_FULL) return 0;
    if (pace == PACE_RANDOM) return $urandom_range(0, 17);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
  endfunction

  function automatic void emit_char(input logic [7:0] c, input logic present);
    smr_pkg::smr_out_t item;
    item.out_char     = c;
    item.char_present = present;
    item.out_line_end = 1'b0;
    step_results.push_back(item);
  endfunction

  function automatic void clear_window();
    foreach (win[i]) win[i] = 8'h00;
    win_fill = 0;
  endfunction

  function automatic logic [7:0] pop_oldest_char();
    logic [7:0] c;
    c = win[0];
    for (int i = 0; i < 7; i++) win[i] = win[i + 1];
    win[7] = 8'h00;
    if (win_fill > 0) win_fill--;
    return c;
  endfunction

  function automatic void predict_rewrite(input smr_pkg::smr_in_t req);
    int unsigned       plen;
    int unsigned       rlen;
    bit                hit;
    smr_pkg::smr_out_t item;
    step_results.delete();
    plen = (pat_len_q == 4'd0) ? 1 : ((pat_len_q > 4'd8) ? 8 : pat_len_q);
    rlen = (rep_len_q > 4'd8) ? 8 : rep_len_q;
    if (win_fill < 8) begin
      win[win_fill] = req.in_char;
      win_fill++;
    end
    hit = 1'b1;
    for (int i = 0; i < plen; i++) begin
      if (win[i] != pat_bytes_q[8*i +: 8]) hit = 1'b0;
    end
    if (!replaced && win_fill == plen && hit) begin
      for (int i = 0; i < rlen; i++) emit_char(rep_bytes_q[8*i +: 8], 1'b1);
      clear_window();
      replaced = 1'b1;
      matches_replaced++;
    end else if (win_fill >= plen) begin
      emit_char(pop_oldest_char(), 1'b1);
    end
    if (req.in_line_end) begin
      while (win_fill > 0 && step_results.size() < 8) emit_char(pop_oldest_char(), 1'b1);
      if (step_results.size() == 0) emit_char(8'h00, 1'b0);
      item = step_results.pop_back();
      item.out_line_end = 1'b1;
      step_results.push_back(item);
      clear_window();
      replaced = 1'b0;
    end
  endfunction

  function automatic stim_row_t row_char(input logic [7:0] c, input logic line_end);
    stim_row_t r;
    r.kind            = STEP_CHAR;
    r.reg_index       = '0;
    r.value           = '0;
    r.req.in_char     = c;
    r.req.in_line_end = line_end;
    r.has_fixed       = 1'b0;
    r.fixed           = '0;
    return r;
  endfunction

  function automatic stim_row_t row_char_fixed(input logic [7:0] c, input logic line_end,
                                               input smr_pkg::smr_out_t result);
    stim_row_t r;
    r           = row_char(c, line_end);
    r.has_fixed = 1'b1;
    r.fixed     = result;
    return r;
  endfunction

  function automatic stim_row_t row_write(input logic [smr_pkg::CFG_INDEX_W-1:0] idx,
                                          input logic [smr_pkg::CFG_DATA_W-1:0] val);
    stim_row_t r;
    r           = row_char(8'h00, 1'b0);
    r.kind      = STEP_WRITE;
    r.reg_index = idx;
    r.value     = val;
    return r;
  endfunction

  task automatic write_reg(input logic [smr_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [smr_pkg::CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      smr_pkg::REG_PATTERN_BYTES:      pat_bytes_q = val;
      smr_pkg::REG_PATTERN_LENGTH:     pat_len_q   = val[3:0];
      smr_pkg::REG_REPLACEMENT_BYTES:  rep_bytes_q = val;
      smr_pkg::REG_REPLACEMENT_LENGTH: rep_len_q   = val[3:0];
      default: ;
    endcase
  endtask

  task automatic push_char(input smr_pkg::smr_in_t req, input bit use_fixed,
                           input smr_pkg::smr_out_t fixed);
    int gap;
    gap = pick_wait(send_pace);
    cfg_write <= 1'b0;
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_data  <= req;
    do @(posedge clk); while (char_stall !== 1'b0);
    predict_rewrite(req);
    if (use_fixed) begin
      pending_results.push_back(fixed);
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
  endtask

  // Registers may only change once the core has drained every request.
  task automatic settle();
    char_valid <= 1'b0;
    cfg_write  <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int phase_no);
    logic [7:0]       alpha [4];
    logic [7:0]       line_chars [$];
    logic [3:0]       plen_reg;
    logic [3:0]       rlen_reg;
    logic [63:0]      pat;
    logic [63:0]      len_word;
    int               plen;
    int               n_lines;
    int               len;
    int               pos;
    int               cut;
    bit               close_line;
    smr_pkg::smr_in_t req;
    settle();
    phase_count++;
    foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       plen_reg = 4'd0;
      1:       plen_reg = 4'($urandom_range(9, 15));
      default: plen_reg = 4'($urandom_range(1, 8));
    endcase
    rlen_reg = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
    plen = (plen_reg == 4'd0) ? 1 : ((plen_reg > 4'd8) ? 8 : plen_reg);
    pat = {$urandom(), $urandom()};
    for (int i = 0; i < plen; i++) pat[8*i +: 8] = alpha[$urandom_range(0, 3)];
    write_reg(smr_pkg::REG_PATTERN_BYTES, pat);
    len_word = ($urandom_range(0, 3) == 0) ? {$urandom(), $urandom()} : 64'd0;
    len_word[3:0] = plen_reg;
    write_reg(smr_pkg::REG_PATTERN_LENGTH, len_word);
    write_reg(smr_pkg::REG_REPLACEMENT_BYTES, {$urandom(), $urandom()});
    len_word = ($urandom_range(0, 3) == 0) ? {$urandom(), $urandom()} : 64'd0;
    len_word[3:0] = rlen_reg;
    write_reg(smr_pkg::REG_REPLACEMENT_LENGTH, len_word);
    send_pace = pace_t'($urandom_range(0, 2));
    recv_pace = pace_t'($urandom_range(0, 2));
    if (phase_no == 1) begin
      send_pace       = PACE_FULL;
      hold_off_cycles = 120;
    end
    n_lines = $urandom_range(1, 4);
    for (int l = 0; l < n_lines; l++) begin
      line_chars.delete();
      if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(1, 10);
        repeat (len) line_chars.push_back(8'($urandom_range(0, 255)));
      end else begin
        len = (phase_no == 1 && l == 0) ? 36 : $urandom_range(0, 10);
        repeat (len) begin
          line_chars.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                            : alpha[$urandom_range(0, 3)]);
        end
        if ($urandom_range(0, 3) != 0) begin
          cut = ($urandom_range(0, 3) == 0) ? plen - 1 : plen;
          pos = $urandom_range(0, line_chars.size());
          for (int j = 0; j < cut; j++) line_chars.insert(pos + j, pat[8*j +: 8]);
        end
        if (line_chars.size() == 0) line_chars.push_back(alpha[0]);
      end
      close_line = (l < n_lines - 1) || ($urandom_range(0, 3) != 0);
      foreach (line_chars[j]) begin
        req.in_char     = line_chars[j];
        req.in_line_end = close_line && (j == line_chars.size() - 1);
        push_char(req, 1'b0, '0);
        random_items++;
      end
    end
  endtask

  // Result side: a fresh wait before each request, or one long hold-off when asked.
  initial begin
    int n;
    result_stall <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_off_cycles > 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        n = pick_wait(recv_pace);
      end
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (result_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (char_valid && char_stall) input_stall_cycles++;
      if (result_valid === 1'b1 && result_stall === 1'b0) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: out_char %02h char_present %0b out_line_end %0b",
                 result_data.out_char, result_data.char_present, result_data.out_line_end);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (result_data.out_char !== want.out_char) begin
            $error("out_char: expected %02h, got %02h", want.out_char, result_data.out_char);
            fail_count++;
          end
          if (result_data.char_present !== want.char_present) begin
            $error("char_present: expected %0b, got %0b",
                   want.char_present, result_data.char_present);
            fail_count++;
          end
          if (result_data.out_line_end !== want.out_line_end) begin
            $error("out_line_end: expected %0b, got %0b",
                   want.out_line_end, result_data.out_line_end);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    int phase_no;
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    char_valid <= 1'b0;
    char_data  <= '0;
    directed_rows = '{
      row_char(8'h00, 1'b0),
      row_char_fixed(8'h00, 1'b1, smr_pkg::smr_out_t'{8'h00, 1'b1, 1'b1}),
      row_char_fixed(8'hFF, 1'b1, smr_pkg::smr_out_t'{8'hFF, 1'b1, 1'b1}),
      row_char_fixed(8'h00, 1'b1, smr_pkg::smr_out_t'{8'h00, 1'b0, 1'b1}),
      row_write(smr_pkg::REG_PATTERN_BYTES, 64'h6261),
      row_write(smr_pkg::REG_PATTERN_LENGTH, 64'd2),
      row_write(smr_pkg::REG_REPLACEMENT_BYTES, 64'h5A5958),
      row_write(smr_pkg::REG_REPLACEMENT_LENGTH, 64'd3),
      row_char(8'h63, 1'b0),
      row_char(8'h61, 1'b0),
      row_char(8'h62, 1'b0),
      row_char(8'h61, 1'b0),
      row_char(8'h62, 1'b1),
      row_write(smr_pkg::REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF),
      row_write(smr_pkg::REG_PATTERN_LENGTH, 64'd15),
      row_write(smr_pkg::REG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF),
      row_write(smr_pkg::REG_REPLACEMENT_LENGTH, 64'd15),
      row_char(8'hFF, 1'b0),
      row_char(8'hFF, 1'b0),
      row_char(8'hFF, 1'b0),
      row_char(8'hFF, 1'b0),
      row_char(8'hFF, 1'b0),
      row_char(8'hFF, 1'b0),
      row_char(8'hFF, 1'b0),
      row_char(8'hFF, 1'b1),
      row_write(smr_pkg::REG_PATTERN_BYTES, 64'h41),
      row_write(smr_pkg::REG_PATTERN_LENGTH, 64'd0),
      row_write(smr_pkg::REG_REPLACEMENT_LENGTH, 64'd0),
      row_char_fixed(8'h41, 1'b1, smr_pkg::smr_out_t'{8'h00, 1'b0, 1'b1}),
      row_write(smr_pkg::REG_PATTERN_BYTES, 64'h7A79_7877),
      row_write(smr_pkg::REG_PATTERN_LENGTH, 64'd4),
      row_char(8'h71, 1'b0),
      row_char(8'h72, 1'b0),
      row_char(8'h73, 1'b0),
      row_char(8'h70, 1'b0),
      row_write(smr_pkg::REG_PATTERN_LENGTH, 64'd1),
      row_char(8'h6B, 1'b1)
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == STEP_WRITE) begin
        if (k > 0 && directed_rows[k-1].kind == STEP_CHAR) settle();
        write_reg(directed_rows[k].reg_index, directed_rows[k].value);
      end else begin
        push_char(directed_rows[k].req, directed_rows[k].has_fixed, directed_rows[k].fixed);
        directed_items++;
      end
    end
    phase_no = 0;
    while (random_items < RANDOM_ITEMS) begin
      run_phase(phase_no);
      phase_no++;
    end
    settle();
    $display("Sent %0d character requests (%0d directed, %0d random) in %0d random setups.",
             directed_items + random_items, directed_items, random_items, phase_count);
    $display("Checked %0d results with %0d replacements; input was held off for %0d cycles.",
             results_checked, matches_replaced, input_stall_cycles);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("stream_first_match_replace_core verification clean");
    end else begin
      $display("stream_first_match_replace_core verification failed");
    end
    $finish;
  end

endmodule
